// ===== hw/rtl/mcp_pkg.sv =====
// ----------------------------------------------------------------------------
// mcp_pkg
// Shared types and constants for the masked column projection unit.
// ----------------------------------------------------------------------------
package mcp_pkg;

    localparam int DATA_W     = 16;
    localparam int MAX_ROWS   = 4096;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int CROSS_W    = 45;
    localparam int NORM_W     = 43;
    localparam int FRAC_SHIFT = 16;
    localparam int RES_W      = 32;

    // |cross_sum| fits in the same width as the signed sum, read as unsigned
    localparam int MAG_W      = CROSS_W;
    // dividend is |cross_sum| scaled into Q16.16
    localparam int NUM_W      = MAG_W + FRAC_SHIFT;
    localparam int DIV_STEPS  = NUM_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    // quotient kept to 33 bits, anything above is folded into a sticky flag
    localparam int QUO_W      = RES_W + 1;
    // Q6.24 to Q16.16 when no division happens
    localparam int EMPTY_SHIFT = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RES_W-1:0] POS_LIMIT = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] NEG_LIMIT = {1'b1, {(RES_W-1){1'b0}}};

    // closed column handed from the accumulator to the divider
    typedef struct packed {
        logic [CROSS_W-1:0] cross_sum;
        logic [NORM_W-1:0]  norm_sum;
        logic               last_column;
    } col_sums_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RESULT
    } div_state_t;

endpackage

// ===== hw/rtl/mcp_elem_if.sv =====
// ----------------------------------------------------------------------------
// mcp_elem_if
// Element channel: one matrix element with its vector entry and flags.
// ----------------------------------------------------------------------------
interface mcp_elem_if;
    logic                          valid;
    logic                          ready;
    logic signed [mcp_pkg::DATA_W-1:0] x_sample;
    logic signed [mcp_pkg::DATA_W-1:0] u_weight;
    logic                          present;
    logic                          last_in_column;
    logic                          last_column;

    modport source (
        output valid, x_sample, u_weight, present, last_in_column, last_column,
        input  ready
    );
    modport sink (
        input  valid, x_sample, u_weight, present, last_in_column, last_column,
        output ready
    );
endinterface

// ===== hw/rtl/mcp_result_if.sv =====
// ----------------------------------------------------------------------------
// mcp_result_if
// Result channel: one column weight with its status flags.
// ----------------------------------------------------------------------------
interface mcp_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [mcp_pkg::RES_W-1:0] projection;
    logic                             empty_column;
    logic                             saturated;
    logic                             last_result;

    modport source (
        output valid, projection, empty_column, saturated, last_result,
        input  ready
    );
    modport sink (
        input  valid, projection, empty_column, saturated, last_result,
        output ready
    );
endinterface

// ===== hw/rtl/mcp_accum.sv =====
// ----------------------------------------------------------------------------
// mcp_accum
// Front end: accumulates x*u and u*u over present elements of a column and
// hands the closed sums to the queue on the last element.
// ----------------------------------------------------------------------------
module mcp_accum (
    input  logic               clk,
    input  logic               rst_n,
    mcp_elem_if.sink           item,
    output logic               push,
    output mcp_pkg::col_sums_t push_data,
    input  logic               push_ready
);
    import mcp_pkg::*;

    logic signed [PROD_W-1:0]  prod_xu;
    logic signed [PROD_W-1:0]  prod_uu;
    logic [CROSS_W-1:0]        cross_reg;
    logic [CROSS_W-1:0]        cross_next;
    logic [NORM_W-1:0]         norm_reg;
    logic [NORM_W-1:0]         norm_next;
    logic [CROSS_W-1:0]        cross_sum_upd;
    logic [NORM_W-1:0]         norm_sum_upd;
    logic                      accept;

    assign item.ready = push_ready;
    assign accept     = item.valid && push_ready;

    assign prod_xu = item.x_sample * item.u_weight;
    assign prod_uu = item.u_weight * item.u_weight;

    always_comb
    begin
        cross_sum_upd = cross_reg;
        norm_sum_upd  = norm_reg;
        if (item.present)
        begin
            cross_sum_upd = cross_reg + CROSS_W'(prod_xu);
            // u*u is never negative, so zero extension is exact
            norm_sum_upd  = norm_reg + NORM_W'(unsigned'(prod_uu));
        end
    end

    always_comb
    begin
        cross_next = cross_reg;
        norm_next  = norm_reg;
        if (accept)
        begin
            if (item.last_in_column)
            begin
                cross_next = '0;
                norm_next  = '0;
            end
            else
            begin
                cross_next = cross_sum_upd;
                norm_next  = norm_sum_upd;
            end
        end
    end

    assign push                  = accept && item.last_in_column;
    assign push_data.cross_sum   = cross_sum_upd;
    assign push_data.norm_sum    = norm_sum_upd;
    assign push_data.last_column = item.last_column;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cross_reg <= '0;
            norm_reg  <= '0;
        end
        else
        begin
            cross_reg <= cross_next;
            norm_reg  <= norm_next;
        end
    end

endmodule

// ===== hw/rtl/mcp_queue.sv =====
// ----------------------------------------------------------------------------
// mcp_queue
// Short queue of closed columns between the accumulator and the divider.
// ----------------------------------------------------------------------------
module mcp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mcp_pkg::col_sums_t push_data,
    output logic               push_ready,
    output logic               pop_valid,
    output mcp_pkg::col_sums_t pop_data,
    input  logic               pop
);
    import mcp_pkg::*;

    col_sums_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/mcp_divider.sv =====
// ----------------------------------------------------------------------------
// mcp_divider
// Back end: restoring divider, one quotient bit per cycle, followed by
// Q16.16 saturation into an output register.
// ----------------------------------------------------------------------------
module mcp_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    input  mcp_pkg::col_sums_t pop_data,
    output logic               pop,
    mcp_result_if.source       result
);
    import mcp_pkg::*;

    div_state_t          state_reg;
    div_state_t          state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [NUM_W-1:0]    num_reg;
    logic [NUM_W-1:0]    num_next;
    logic [NORM_W-1:0]   den_reg;
    logic [NORM_W-1:0]   den_next;
    logic [NORM_W-1:0]   rem_reg;
    logic [NORM_W-1:0]   rem_next;
    logic [QUO_W-1:0]    quo_reg;
    logic [QUO_W-1:0]    quo_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic                neg_reg;
    logic                neg_next;
    logic                empty_reg;
    logic                empty_next;
    logic                last_reg;
    logic                last_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [RES_W-1:0]    out_proj_reg;
    logic [RES_W-1:0]    out_proj_next;
    logic                out_empty_reg;
    logic                out_empty_next;
    logic                out_sat_reg;
    logic                out_sat_next;
    logic                out_last_reg;
    logic                out_last_next;

    logic                out_free;
    logic                load_out;
    logic                div_last;
    logic [NORM_W:0]     trial;
    logic                trial_ge;
    logic [NORM_W:0]     trial_diff;
    logic [MAG_W-1:0]    mag;
    logic                c_neg;
    logic                sat_val;
    logic [RES_W-1:0]    clip_val;

    assign out_free = !out_valid_reg || result.ready;
    assign div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    // magnitude of the signed cross sum; -2^44 still fits unsigned
    assign c_neg = pop_data.cross_sum[CROSS_W-1];
    assign mag   = c_neg ? MAG_W'(-pop_data.cross_sum) : MAG_W'(pop_data.cross_sum);

    assign trial      = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ge   = (trial >= {1'b0, den_reg});
    assign trial_diff = trial - {1'b0, den_reg};

    // saturation to signed 32 bits from sign and magnitude
    always_comb
    begin
        if (!neg_reg)
        begin
            sat_val  = ovf_reg || quo_reg[QUO_W-1] || quo_reg[RES_W-1];
            clip_val = sat_val ? POS_LIMIT : quo_reg[RES_W-1:0];
        end
        else
        begin
            sat_val  = ovf_reg || quo_reg[QUO_W-1]
                    || (quo_reg[RES_W-1] && (|quo_reg[RES_W-2:0]));
            clip_val = sat_val ? NEG_LIMIT : (~quo_reg[RES_W-1:0] + 1'b1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = (pop_data.norm_sum == '0) ? ST_RESULT : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:   pop      = pop_valid;
            ST_DIV:    pop      = 1'b0;
            ST_RESULT: load_out = out_free;
            default:
            begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        ovf_next   = ovf_reg;
        neg_next   = neg_reg;
        empty_next = empty_reg;
        last_next  = last_reg;
        if (pop)
        begin
            neg_next  = c_neg;
            last_next = pop_data.last_column;
            den_next  = pop_data.norm_sum;
            cnt_next  = '0;
            rem_next  = '0;
            num_next  = {mag, {FRAC_SHIFT{1'b0}}};
            if (pop_data.norm_sum == '0)
            begin
                empty_next = 1'b1;
                quo_next   = mag[EMPTY_SHIFT +: QUO_W];
                ovf_next   = |mag[MAG_W-1:EMPTY_SHIFT+QUO_W];
            end
            else
            begin
                empty_next = 1'b0;
                quo_next   = '0;
                ovf_next   = 1'b0;
            end
        end
        else if (state_reg == ST_DIV)
        begin
            cnt_next = cnt_reg + 1'b1;
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            rem_next = trial_ge ? trial_diff[NORM_W-1:0] : trial[NORM_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], trial_ge};
            ovf_next = ovf_reg || quo_reg[QUO_W-1];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_proj_next  = out_proj_reg;
        out_empty_next = out_empty_reg;
        out_sat_next   = out_sat_reg;
        out_last_next  = out_last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_proj_next  = clip_val;
            out_empty_next = empty_reg;
            out_sat_next   = sat_val;
            out_last_next  = last_reg;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg       <= num_next;
        den_reg       <= den_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        ovf_reg       <= ovf_next;
        neg_reg       <= neg_next;
        empty_reg     <= empty_next;
        last_reg      <= last_next;
        out_proj_reg  <= out_proj_next;
        out_empty_reg <= out_empty_next;
        out_sat_reg   <= out_sat_next;
        out_last_reg  <= out_last_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.projection   = out_proj_reg;
    assign result.empty_column = out_empty_reg;
    assign result.saturated    = out_sat_reg;
    assign result.last_result  = out_last_reg;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg <= CNT_W'(DIV_STEPS - 1))
        else $error("divider step count out of range");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && !out_free) |=> state_reg == ST_RESULT)
        else $error("finished quotient dropped while output stalled");

    a_word_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("output word raised outside result state");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_IDLE)
        else $error("queue popped while divider busy");
`endif

endmodule

// ===== hw/rtl/masked_column_projection_unit.sv =====
// ----------------------------------------------------------------------------
// masked_column_projection_unit
// Masked least-squares column projection: sum(x*u) / sum(u*u) per column,
// signed Q16.16 with saturation and empty-column flag.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle; the multiply-accumulate front never stalls
// unless the two-entry column queue is full.
// Column path: closed sums pass through the queue, a divider load, 61 divide
// steps and saturation to a valid result; an empty column skips the divide steps.
// The bit-serial divider takes a new column from the queue only when idle.
// Reset (rst_n, async, active low) clears the sums, queue and divider control.
// ----------------------------------------------------------------------------
module masked_column_projection_unit (
    input  logic         clk,
    input  logic         rst_n,
    mcp_elem_if.sink     item,
    mcp_result_if.source result
);
    import mcp_pkg::*;

    logic      push;
    col_sums_t push_data;
    logic      push_ready;
    logic      pop_valid;
    col_sums_t pop_data;
    logic      pop;

    mcp_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    mcp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop        (pop)
    );

    mcp_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop),
        .result    (result)
    );

endmodule
